>>> rtl/clpd_pkg.sv
// Shared constants, types and state codes of the closest-pair distance scan core.
package clpd_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 8;

	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);

	// one stored point: y above x
	localparam int PT_W = 2 * COORD_WIDTH;

	// |a - b| of two coordinates fits COORD_WIDTH bits unsigned
	localparam int SQ_W  = 2 * COORD_WIDTH;
	localparam int SUM_W = SQ_W + 1;

	localparam int DSQ_W  = 34;
	localparam int DFIX_W = 25;

	// square root of dist_squared << (2*FRAC_BITS)
	localparam int RAD_W  = DSQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W = RAD_W / 2;
	localparam int STEP_W = $clog2(ROOT_W + 1);

	localparam int OUT_FIELDS_W = DSQ_W + DFIX_W + 4 * COORD_WIDTH;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_SQRT  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sq_stat_t;

endpackage

>>> rtl/clpd_isqrt.sv
// Iterative integer square root, one root bit per cycle.
module clpd_isqrt import clpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output sq_stat_t          stat,
	output logic [ROOT_W-1:0] root
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] rem_nx;
	logic              ge;

	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = (rem_sh >= trial);
		rem_nx = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= rem_nx[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

>>> rtl/closest_pair_distance_scan_core.sv
// Closest-pair distance scan core: point store, pair scan and result register.
//
// Points stream in one item per cycle while the core is idle (tready high) and are
// written to a 64-entry point store in arrival order; points beyond capacity are
// dropped and reported as overflow. The item marked tlast is stored like the others
// and then, with at least two points stored, starts an exhaustive scan of all pairs
// i<j (i outer, j inner). The store has a single registered read port, so the scan
// reads one point j per pair plus one extra read per outer step to fetch point i.
// The distance pipeline then drains and the bit-serial square-root unit works out
// ROOT_W (25) root bits of the result before the hand-over to the output register.
// The input side is held off (tready low) from the tlast item until the result is
// in the output register; points of the next set may load while that result waits
// to be taken. The first pair with the strictly smallest squared distance wins
// ties. With fewer than two points found is 0, both distances read all ones and
// the coordinates zero. No clearing pass is needed after reset.
module closest_pair_distance_scan_core import clpd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [PT_W-1:0]        s_axis_tdata,  // point_x, point_y
	input  logic                   s_axis_tlast,  // last_point

	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// dist_squared, dist_fixed, first_x, first_y, second_x, second_y, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]             m_axis_tuser   // found, overflow
);

	state_t state_q;

	// point store and its counters
	logic [PT_W-1:0]   mem [MAX_POINTS];
	logic [CNT_W-1:0]  cnt_q;
	logic              drop_q;
	logic              in_acc;
	logic              room;
	logic [CNT_W-1:0]  cnt_nx;

	// scan sequencer
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic              issue_i_q;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;

	// distance pipeline
	logic              v_s1;
	logic              isi_s1;
	logic [PT_W-1:0]   rd_s1;
	logic [COORD_WIDTH-1:0] pix_q, piy_q;

	logic [COORD_WIDTH:0]   dxw, dyw;
	logic [COORD_WIDTH-1:0] adx, ady;

	logic              v_s2;
	logic [COORD_WIDTH-1:0] dx_s2, dy_s2;
	logic [PT_W-1:0]   pa_s2, pb_s2;

	logic              v_s3;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;
	logic [PT_W-1:0]   pa_s3, pb_s3;
	logic [SUM_W-1:0]  sum_s3;

	// running best
	logic              have_q;
	logic [SUM_W-1:0]  best_q;
	logic [PT_W-1:0]   best_a_q, best_b_q;

	// root unit
	logic              sq_start;
	sq_stat_t          sq_stat;
	logic [ROOT_W-1:0] sq_root;

	// output register
	logic              out_free;
	logic              out_load;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [1:0]        out_user_q;
	logic              pipe_empty;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign room          = (cnt_q < CNT_W'(MAX_POINTS));
	assign cnt_nx        = room ? (cnt_q + 1'b1) : cnt_q;

	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign out_free   = !out_valid_q || m_axis_tready;
	assign out_load   = (state_q == ST_DONE) && out_free;
	assign sq_start   = (state_q == ST_DRAIN) && pipe_empty && have_q;

	assign rd_en   = (state_q == ST_SCAN);
	assign rd_addr = issue_i_q ? i_q[ADDR_W-1:0] : j_q[ADDR_W-1:0];

	// point store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && room)
			mem[cnt_q[ADDR_W-1:0]] <= s_axis_tdata;
		if (rd_en)
			rd_s1 <= mem[rd_addr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			issue_i_q <= 1'b0;
			v_s1      <= 1'b0;
			isi_s1    <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			have_q    <= 1'b0;
		end else begin
			v_s1   <= rd_en;
			isi_s1 <= issue_i_q;
			v_s2   <= v_s1 && !isi_s1;
			v_s3   <= v_s2;

			if (v_s3 && (!have_q || (sum_s3 < best_q)))
				have_q <= 1'b1;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= cnt_nx;
						if (!room)
							drop_q <= 1'b1;
						if (s_axis_tlast) begin
							have_q    <= 1'b0;
							i_q       <= '0;
							issue_i_q <= 1'b1;
							state_q   <= (cnt_nx >= CNT_W'(2)) ? ST_SCAN : ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (issue_i_q) begin
						issue_i_q <= 1'b0;
						j_q       <= i_q + 1'b1;
					end else if (j_q == cnt_q - 1'b1) begin
						if (i_q + CNT_W'(2) == cnt_q) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q       <= i_q + 1'b1;
							issue_i_q <= 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty)
						state_q <= have_q ? ST_SQRT : ST_DONE;
				end
				ST_SQRT: begin
					if (sq_stat.done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						cnt_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stage 1: absolute coordinate differences against the held point i
	always_comb begin
		dxw = {pix_q[COORD_WIDTH-1], pix_q}
			- {rd_s1[COORD_WIDTH-1], rd_s1[COORD_WIDTH-1:0]};
		dyw = {piy_q[COORD_WIDTH-1], piy_q}
			- {rd_s1[PT_W-1], rd_s1[PT_W-1:COORD_WIDTH]};
		adx = dxw[COORD_WIDTH] ? COORD_WIDTH'(~dxw + 1'b1) : dxw[COORD_WIDTH-1:0];
		ady = dyw[COORD_WIDTH] ? COORD_WIDTH'(~dyw + 1'b1) : dyw[COORD_WIDTH-1:0];
	end

	assign sum_s3 = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk) begin
		if (v_s1 && isi_s1) begin
			pix_q <= rd_s1[COORD_WIDTH-1:0];
			piy_q <= rd_s1[PT_W-1:COORD_WIDTH];
		end
		dx_s2  <= adx;
		dy_s2  <= ady;
		pa_s2  <= {piy_q, pix_q};
		pb_s2  <= rd_s1;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		pa_s3  <= pa_s2;
		pb_s3  <= pb_s2;
		// strict less-than keeps the earliest minimal pair
		if (v_s3 && (!have_q || (sum_s3 < best_q))) begin
			best_q   <= sum_s3;
			best_a_q <= pa_s3;
			best_b_q <= pb_s3;
		end
	end

	clpd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({DSQ_W'(best_q), {(2 * FRAC_BITS){1'b0}}}),
		.stat     (sq_stat),
		.root     (sq_root)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (have_q) begin
				out_data_q <= {{OUT_PAD_W{1'b0}}, best_b_q, best_a_q,
					DFIX_W'(sq_root), DSQ_W'(best_q)};
				out_user_q <= {drop_q, 1'b1};
			end else begin
				out_data_q <= {{OUT_PAD_W{1'b0}}, {(2 * PT_W){1'b0}},
					{DFIX_W{1'b1}}, {DSQ_W{1'b1}}};
				out_user_q <= {drop_q, 1'b0};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance pipeline active outside the scan");

	a_sqrt_start: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> (have_q && !sq_stat.busy))
		else $error("root unit started without a pair or while busy");

	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (cnt_q == '0 && !drop_q && state_q == ST_IDLE))
		else $error("set not cleared after result load");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the hand-over state");

endmodule

>>> sim/tb_closest_pair_distance_scan_core.sv
// Self-checking testbench for the closest-pair distance scan core.
module tb_closest_pair_distance_scan_core;
	import clpd_pkg::*;

	localparam int ITEMS      = 600;
	localparam int CALM_ITEMS = 100;
	localparam int LIMIT      = 400000;
	localparam int SETTLE     = 64;

	// result field offsets in m_axis_tdata, lowest first
	localparam int OFS_DFIX = DSQ_W;
	localparam int OFS_AX   = OFS_DFIX + DFIX_W;
	localparam int OFS_AY   = OFS_AX + COORD_WIDTH;
	localparam int OFS_BX   = OFS_AY + COORD_WIDTH;
	localparam int OFS_BY   = OFS_BX + COORD_WIDTH;

	typedef enum {CLOUD_WIDE, CLOUD_TIGHT, CLOUD_GRID} cloud_shape_t;

	typedef struct {
		logic                          found;
		logic                          overflow;
		logic [DSQ_W-1:0]              dsq;
		logic [DFIX_W-1:0]             dfix;
		logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
	} pair_result_t;

	// Keeps its own copy of the point store and predicts the pair of each set.
	class closest_pair_tracker;
		logic signed [COORD_WIDTH-1:0] px [MAX_POINTS];
		logic signed [COORD_WIDTH-1:0] py [MAX_POINTS];
		int unsigned  stored;
		bit           dropped;
		pair_result_t awaited_pairs[$];
		int errors, sets, empty_sets, overflow_sets, pairs_checked;

		function new();
			stored = 0;
			dropped = 0;
			errors = 0;
			sets = 0;
			empty_sets = 0;
			overflow_sets = 0;
			pairs_checked = 0;
		endfunction

		// floor square root, one result bit per pass
		function longint unsigned floor_root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'h1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		// exhaustive scan, i outer and j inner, strict less-than keeps the first pair
		function pair_result_t scan_closest_pair();
			pair_result_t    r;
			longint unsigned d, best;
			int              i, j, dx, dy, bi, bj;
			bit              have;
			have = 0;
			best = 0;
			bi = 0;
			bj = 0;
			for (i = 0; i < stored; i++)
				for (j = i + 1; j < stored; j++) begin
					dx = px[i] - px[j];
					dy = py[i] - py[j];
					d = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
					if (!have || d < best) begin
						have = 1;
						best = d;
						bi = i;
						bj = j;
					end
				end
			r.overflow = dropped;
			if (have) begin
				// 2*65535^2 << 16 stays well inside 64 bits; root fits 25 bits
				r.found = 1'b1;
				r.dsq   = best[DSQ_W-1:0];
				r.dfix  = DFIX_W'(floor_root(best << (2 * FRAC_BITS)));
				r.ax    = px[bi];
				r.ay    = py[bi];
				r.bx    = px[bj];
				r.by    = py[bj];
			end else begin
				r.found = 1'b0;
				r.dsq   = '1;
				r.dfix  = '1;
				r.ax    = '0;
				r.ay    = '0;
				r.bx    = '0;
				r.by    = '0;
			end
			return r;
		endfunction

		function void note_point(logic signed [COORD_WIDTH-1:0] x, y, logic last);
			pair_result_t r;
			if (stored < MAX_POINTS) begin
				px[stored] = x;
				py[stored] = y;
				stored++;
			end else
				dropped = 1;
			if (!last)
				return;
			r = scan_closest_pair();
			awaited_pairs.insert(awaited_pairs.size(), r);
			sets++;
			if (!r.found)
				empty_sets++;
			if (r.overflow)
				overflow_sets++;
			stored = 0;
			dropped = 0;
		endfunction

		function void check_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: pair %0d %s mismatch, expected %0h, actual %0h",
					$time, pairs_checked, name, want, got);
			end
		endfunction

		function void check_pair_result(logic [OUT_TDATA_W-1:0] data, logic [1:0] user);
			pair_result_t w;
			if (awaited_pairs.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual tdata %0h tuser %0b",
					$time, data, user);
				return;
			end
			w = awaited_pairs.pop_front();
			check_field("found", w.found, user[0]);
			check_field("overflow", w.overflow, user[1]);
			check_field("dist_squared", w.dsq, data[DSQ_W-1:0]);
			check_field("dist_fixed", w.dfix, data[OFS_DFIX +: DFIX_W]);
			check_field("first_x", $unsigned(w.ax), data[OFS_AX +: COORD_WIDTH]);
			check_field("first_y", $unsigned(w.ay), data[OFS_AY +: COORD_WIDTH]);
			check_field("second_x", $unsigned(w.bx), data[OFS_BX +: COORD_WIDTH]);
			check_field("second_y", $unsigned(w.by), data[OFS_BY +: COORD_WIDTH]);
			check_field("pad", 0, data[OUT_TDATA_W-1:OUT_FIELDS_W]);
			pairs_checked++;
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [PT_W-1:0]        s_axis_tdata;   // point_x, point_y
	logic                   s_axis_tlast;   // last_point
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// dist_squared, dist_fixed, first_x, first_y, second_x, second_y, zero pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;   // found, overflow

	closest_pair_tracker tracker;
	int unsigned         cycles;
	int                  points_sent;
	bit                  calm;

	closest_pair_distance_scan_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d pairs still awaited",
				cycles, tracker.awaited_pairs.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: ready drops in bursts until the calm tail
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_pair_result(m_axis_tdata, m_axis_tuser);

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_point(input logic signed [COORD_WIDTH-1:0] x, y, input logic last);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {y, x};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.note_point(x, y, last);
		points_sent++;
		calm = points_sent >= ITEMS - CALM_ITEMS;
		@(negedge clk);
	endtask

	// hold the input side off until every awaited pair has been taken
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (tracker.awaited_pairs.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_set(input int n, input cloud_shape_t shape);
		int                            k, cx, cy;
		logic signed [COORD_WIDTH-1:0] x, y;
		cx = int'($urandom_range(0, 64000)) - 32000;
		cy = int'($urandom_range(0, 64000)) - 32000;
		for (k = 0; k < n; k++) begin
			case (shape)
				CLOUD_WIDE: begin
					x = COORD_WIDTH'($urandom);
					y = COORD_WIDTH'($urandom);
				end
				CLOUD_TIGHT: begin
					x = COORD_WIDTH'(cx + int'($urandom_range(0, 30)) - 15);
					y = COORD_WIDTH'(cy + int'($urandom_range(0, 30)) - 15);
				end
				default: begin
					// small grid: duplicates and equal distances are common
					x = COORD_WIDTH'(int'($urandom_range(0, 6)) - 3);
					y = COORD_WIDTH'(int'($urandom_range(0, 6)) - 3);
				end
			endcase
			send_point(x, y, k == n - 1);
		end
	endtask

	initial begin
		int           n, pick;
		cloud_shape_t shape;
		tracker = new();
		cycles = 0;
		points_sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// lone point: no pair
		send_point(16'sd0, 16'sd0, 1'b1);
		// opposite corners: largest distance on both diagonals
		send_point(-16'sd32768, -16'sd32768, 1'b0);
		send_point(16'sd32767, 16'sd32767, 1'b1);
		send_point(16'sd32767, -16'sd32768, 1'b0);
		send_point(-16'sd32768, 16'sd32767, 1'b1);
		// coincident points, zero distance
		send_point(-16'sd1, -16'sd1, 1'b0);
		send_point(-16'sd1, -16'sd1, 1'b1);
		// ties: the first minimal pair in scan order wins
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd1, 16'sd0, 1'b0);
		send_point(16'sd0, 16'sd1, 1'b1);
		send_point(16'sd10, 16'sd10, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd10, 16'sd11, 1'b0);
		send_point(16'sd1, 16'sd0, 1'b1);
		// alternating bit patterns
		send_point(16'sh5555, 16'shAAAA, 1'b0);
		send_point(16'shAAAA, 16'sh5555, 1'b1);
		wait_drained();

		// capacity: exactly full, one dropped point marked last, several dropped
		send_set(MAX_POINTS, CLOUD_TIGHT);
		send_set(MAX_POINTS + 1, CLOUD_GRID);
		send_set(MAX_POINTS + 6, CLOUD_WIDE);

		while (points_sent < ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				n = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 6);
			else if (pick == 1)
				n = 1;
			else
				n = $urandom_range(2, 12);
			shape = cloud_shape_t'($urandom_range(0, 2));
			send_set(n, shape);
			if (points_sent >= ITEMS / 2 && points_sent - n < ITEMS / 2)
				wait_drained();
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.awaited_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d points in %0d sets: %0d without a pair, %0d with dropped points",
			points_sent, tracker.sets, tracker.empty_sets, tracker.overflow_sets);
		$display("%0d results checked in %0d cycles", tracker.pairs_checked, cycles);
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
rtl/clpd_pkg.sv
rtl/clpd_isqrt.sv
rtl/closest_pair_distance_scan_core.sv
sim/tb_closest_pair_distance_scan_core.sv
